// ===== hdl/rbtq_pkg.sv =====
// Shared types, codes and the pacing table for the retry/backoff transmit queue.
`timescale 1ns / 1ps
package rbtq_pkg;

  localparam int unsigned QueueDepthDef    = 8;
  localparam int unsigned MaxFrameBytesDef = 256;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned KindW  = 4;
  localparam int unsigned RetryW = 8;
  localparam int unsigned LenW   = 9;
  localparam int unsigned HalfW  = 8;   // widest half pacing interval is 250

  localparam logic [TimeW-1:0] RetryBase = TimeW'(10);

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_TICK    = 1'b1
  } rbtq_op_e;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOT_DUE  = 3'd4,
    ST_SENT     = 3'd5,
    ST_RETRY    = 3'd6,
    ST_DROPPED  = 3'd7
  } rbtq_status_e;

  typedef struct packed {
    rbtq_op_e          op;
    logic [AddrW-1:0]  dest_addr;
    logic [KindW-1:0]  msg_kind;
    logic [RetryW-1:0] retry_limit;
    logic [LenW-1:0]   frame_len;
    logic [TimeW-1:0]  now_time;
    logic              link_ok;
  } rbtq_item_t;

  typedef struct packed {
    rbtq_status_e      status;
    logic              send_attempt;
    logic [AddrW-1:0]  send_addr;
    logic [LenW-1:0]   send_len;
    logic [RetryW-1:0] retries;
  } rbtq_res_t;

  // Half of the pacing interval of a kind; kinds 13 and up are "other" (100).
  function automatic logic [HalfW-1:0] pace_half(input logic [KindW-1:0] kind);
    logic [HalfW-1:0] h;
    case (kind)
      4'd0:    h = 8'd25;
      4'd1:    h = 8'd0;
      4'd2:    h = 8'd40;
      4'd3:    h = 8'd20;
      4'd4:    h = 8'd125;
      4'd5:    h = 8'd30;
      4'd6:    h = 8'd60;
      4'd7:    h = 8'd250;
      4'd8:    h = 8'd250;
      4'd9:    h = 8'd250;
      4'd10:   h = 8'd1;
      4'd11:   h = 8'd250;
      4'd12:   h = 8'd100;
      default: h = 8'd50;
    endcase
    return h;
  endfunction

endpackage

// ===== hdl/retry_backoff_tx_queue_core.sv =====
// Top level of the transmit queue with per-slot retry and backoff.
// Circular transmit queue with retry/backoff scheduling.
// Input channel (in_valid_i / in_stall_o) carries one item per transfer:
// an enqueue (operation 0) stores address, kind, retry budget and length at
// the tail slot, due at now_time; a tick (operation 1) offers the head slot
// when due and link_ok tells whether the radio took it.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// item: status, offer flag, slot number (for the external payload buffer),
// offered address and length, and retries left.
// The result passes through the input register, then the decision logic
// feeding the result register. Throughput: one item per cycle while the
// receiver does not stall; the head/tail slot access, a 48-bit compare and
// a three-operand 48-bit add sit between those two registers.
// When the receiver stalls, the held result stays put, the item in the input
// register waits, and in_stall_o rises; nothing is dropped.
// Reset clears all valid bits and both pointers; the queue starts empty and
// slot contents are only read after an enqueue has written them.
`timescale 1ns / 1ps
module retry_backoff_tx_queue_core #(
  parameter int unsigned QUEUE_DEPTH     = rbtq_pkg::QueueDepthDef,
  parameter int unsigned MAX_FRAME_BYTES = rbtq_pkg::MaxFrameBytesDef,
  localparam int unsigned PtrW           = $clog2(QUEUE_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [rbtq_pkg::AddrW-1:0]  dest_addr_i,
  input  logic [rbtq_pkg::KindW-1:0]  msg_kind_i,
  input  logic [rbtq_pkg::RetryW-1:0] retry_limit_i,
  input  logic [rbtq_pkg::LenW-1:0]   frame_len_i,
  input  logic [rbtq_pkg::TimeW-1:0]  now_time_i,
  input  logic                        link_ok_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic                        send_attempt_o,
  output logic [PtrW-1:0]             slot_o,
  output logic [rbtq_pkg::AddrW-1:0]  send_addr_o,
  output logic [rbtq_pkg::LenW-1:0]   send_len_o,
  output logic [rbtq_pkg::RetryW-1:0] retries_remaining_o
);
  import rbtq_pkg::*;

  rbtq_item_t      in_item;
  rbtq_item_t      held_item;
  logic            held_vld;
  logic            advance;
  rbtq_res_t       res;
  rbtq_res_t       res_q;
  logic [PtrW-1:0] slot;

  always_comb begin
    in_item.op          = rbtq_op_e'(operation_i);
    in_item.dest_addr   = dest_addr_i;
    in_item.msg_kind    = msg_kind_i;
    in_item.retry_limit = retry_limit_i;
    in_item.frame_len   = frame_len_i;
    in_item.now_time    = now_time_i;
    in_item.link_ok     = link_ok_i;
  end

  rbtq_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .vld_o      (held_vld),
    .item_o     (held_item)
  );

  rbtq_slots #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_slots (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (held_item),
    .res_o     (res),
    .slot_o    (slot)
  );

  rbtq_out_reg #(
    .PtrW (PtrW)
  ) u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (held_vld),
    .advance_o   (advance),
    .res_i       (res),
    .slot_i      (slot),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q),
    .slot_o      (slot_o)
  );

  assign status_o            = res_q.status;
  assign send_attempt_o      = res_q.send_attempt;
  assign send_addr_o         = res_q.send_addr;
  assign send_len_o          = res_q.send_len;
  assign retries_remaining_o = res_q.retries;

endmodule

// ===== hdl/rbtq_in_reg.sv =====
// Input register: holds one accepted item until the queue logic consumes it.
`timescale 1ns / 1ps
module rbtq_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rbtq_pkg::rbtq_item_t item_i,
  input  logic                advance_i,
  output logic                vld_o,
  output rbtq_pkg::rbtq_item_t item_o
);
  import rbtq_pkg::*;

  logic       vld_q;
  logic       vld_d;
  rbtq_item_t item_q;
  logic       take;

  // Stall only while a held item cannot move on this cycle.
  assign in_stall_o = vld_q & ~advance_i;
  assign take       = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== hdl/rbtq_slots.sv =====
// Slot storage, head/tail pointers and the per-item enqueue/tick decision.
`timescale 1ns / 1ps
module rbtq_slots #(
  parameter int unsigned QUEUE_DEPTH     = rbtq_pkg::QueueDepthDef,
  parameter int unsigned MAX_FRAME_BYTES = rbtq_pkg::MaxFrameBytesDef,
  localparam int unsigned PtrW           = $clog2(QUEUE_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  rbtq_pkg::rbtq_item_t item_i,
  output rbtq_pkg::rbtq_res_t  res_o,
  output logic [PtrW-1:0]      slot_o
);
  import rbtq_pkg::*;

  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  logic [AddrW-1:0]  slot_addr_q    [QUEUE_DEPTH];
  logic [KindW-1:0]  slot_kind_q    [QUEUE_DEPTH];
  logic [RetryW-1:0] slot_retries_q [QUEUE_DEPTH];
  logic [TimeW-1:0]  slot_due_q     [QUEUE_DEPTH];
  logic [LenW-1:0]   slot_len_q     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] slot_valid_q, slot_valid_d;
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;

  logic              do_enq;
  logic              do_pop;
  logic              do_retry;
  logic [RetryW-1:0] head_ret;
  logic [TimeW-1:0]  retry_due;

  assign head_ret  = slot_retries_q[head_q];
  assign retry_due = item_i.now_time + RetryBase
                   + TimeW'(pace_half(slot_kind_q[head_q]));

  always_comb begin
    res_o    = '0;
    res_o.status = ST_QUEUED;
    slot_o   = tail_q;
    do_enq   = 1'b0;
    do_pop   = 1'b0;
    do_retry = 1'b0;
    if (item_i.op == OP_ENQUEUE) begin
      if (int'(item_i.frame_len) > MAX_FRAME_BYTES) begin
        res_o.status = ST_TOO_LONG;
      end else if (slot_valid_q[tail_q]) begin
        res_o.status = ST_FULL;
      end else begin
        res_o.status = ST_QUEUED;
        do_enq       = 1'b1;
      end
    end else begin
      slot_o = head_q;
      if (!slot_valid_q[head_q]) begin
        res_o.status = ST_EMPTY;
      end else if (item_i.now_time < slot_due_q[head_q]) begin
        res_o.status  = ST_NOT_DUE;
        res_o.retries = head_ret;
      end else begin
        res_o.send_attempt = 1'b1;
        res_o.send_addr    = slot_addr_q[head_q];
        res_o.send_len     = slot_len_q[head_q];
        if (item_i.link_ok) begin
          res_o.status  = ST_SENT;
          res_o.retries = head_ret;
          do_pop        = 1'b1;
        end else if (head_ret == '0) begin
          res_o.status = ST_DROPPED;
          do_pop       = 1'b1;
        end else begin
          res_o.status  = ST_RETRY;
          res_o.retries = head_ret - RetryW'(1);
          do_retry      = 1'b1;
        end
      end
    end
  end

  always_comb begin
    slot_valid_d = slot_valid_q;
    head_d       = head_q;
    tail_d       = tail_q;
    if (advance_i && do_enq) begin
      slot_valid_d[tail_q] = 1'b1;
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + PtrW'(1);
    end
    if (advance_i && do_pop) begin
      slot_valid_d[head_q] = 1'b0;
      head_d = (head_q == LastPtr) ? '0 : head_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      head_q       <= '0;
      tail_q       <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && do_enq) begin
      slot_addr_q[tail_q]    <= item_i.dest_addr;
      slot_kind_q[tail_q]    <= item_i.msg_kind;
      slot_retries_q[tail_q] <= item_i.retry_limit;
      slot_due_q[tail_q]     <= item_i.now_time;
      slot_len_q[tail_q]     <= item_i.frame_len;
    end else if (advance_i && do_retry) begin
      slot_retries_q[head_q] <= res_o.retries;
      slot_due_q[head_q]     <= retry_due;
    end
  end

endmodule

// ===== hdl/rbtq_out_reg.sv =====
// Result register: one result held until the receiver takes it.
`timescale 1ns / 1ps
module rbtq_out_reg #(
  parameter int unsigned PtrW = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_vld_i,
  output logic                advance_o,
  input  rbtq_pkg::rbtq_res_t res_i,
  input  logic [PtrW-1:0]     slot_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rbtq_pkg::rbtq_res_t res_o,
  output logic [PtrW-1:0]     slot_o
);
  import rbtq_pkg::*;

  logic      vld_q, vld_d;
  rbtq_res_t res_q;
  logic [PtrW-1:0] slot_q;

  // Move on when the result register is empty or is drained this cycle.
  assign advance_o = in_vld_i & (~vld_q | ~out_stall_i);

  always_comb begin
    vld_d = vld_q;
    if (advance_o) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q  <= res_i;
      slot_q <= slot_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;
  assign slot_o      = slot_q;

endmodule

// ===== tb/retry_backoff_tx_queue_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the retry/backoff transmit queue: directed and random frames and ticks.
module retry_backoff_tx_queue_core_tb;
  import rbtq_pkg::*;

  localparam int unsigned Depth       = 8;
  localparam int unsigned MaxLen      = 256;
  localparam int unsigned RetryGapMs  = 10;
  localparam int unsigned OtherKind   = 13;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [AddrW-1:0] AddrMax = '1;
  localparam int unsigned PaceMs [14] = '{50, 0, 80, 40, 250, 60, 120, 500, 500, 500, 3,
                                          500, 200, 100};

  typedef struct packed {
    rbtq_status_e      status;
    logic              attempt;
    logic [2:0]        slot;
    logic [AddrW-1:0]  addr;
    logic [LenW-1:0]   len;
    logic [RetryW-1:0] retries;
  } tx_outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              operation_i = 1'b0;
  logic [AddrW-1:0]  dest_addr_i = '0;
  logic [KindW-1:0]  msg_kind_i = '0;
  logic [RetryW-1:0] retry_limit_i = '0;
  logic [LenW-1:0]   frame_len_i = '0;
  logic [TimeW-1:0]  now_time_i = '0;
  logic              link_ok_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [2:0]        status_o;
  logic              send_attempt_o;
  logic [2:0]        slot_o;
  logic [AddrW-1:0]  send_addr_o;
  logic [LenW-1:0]   send_len_o;
  logic [RetryW-1:0] retries_remaining_o;

  // shadow copy of the queue
  logic [AddrW-1:0]  q_addr    [Depth];
  logic [KindW-1:0]  q_kind    [Depth];
  logic [RetryW-1:0] q_retries [Depth];
  logic [TimeW-1:0]  q_due     [Depth];
  logic [LenW-1:0]   q_len     [Depth];
  logic              q_valid   [Depth];
  logic [2:0]        q_head;
  logic [2:0]        q_tail;

  tx_outcome_t       expected_outcomes[$];
  int unsigned       mismatches = 0;
  int unsigned       gap_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       idle_cycles = 0;
  logic [TimeW-1:0]  clock_ms;

  retry_backoff_tx_queue_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .dest_addr_i        (dest_addr_i),
    .msg_kind_i         (msg_kind_i),
    .retry_limit_i      (retry_limit_i),
    .frame_len_i        (frame_len_i),
    .now_time_i         (now_time_i),
    .link_ok_i          (link_ok_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .send_attempt_o     (send_attempt_o),
    .slot_o             (slot_o),
    .send_addr_o        (send_addr_o),
    .send_len_o         (send_len_o),
    .retries_remaining_o(retries_remaining_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [47:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Applies one item to the shadow queue and returns the result it should produce.
  function automatic tx_outcome_t next_outcome(input rbtq_item_t it);
    tx_outcome_t o;
    logic [2:0] h;
    logic [2:0] t;
    int unsigned k;
    h = q_head;
    t = q_tail;
    o = '0;
    if (it.op == OP_ENQUEUE) begin
      o.slot = t;
      if (it.frame_len > MaxLen) begin
        o.status = ST_TOO_LONG;
      end else if (q_valid[t]) begin
        o.status = ST_FULL;
      end else begin
        q_addr[t]    = it.dest_addr;
        q_kind[t]    = it.msg_kind;
        q_retries[t] = it.retry_limit;
        q_due[t]     = it.now_time;
        q_len[t]     = it.frame_len;
        q_valid[t]   = 1'b1;
        q_tail       = t + 3'd1;
        o.status     = ST_QUEUED;
      end
    end else begin
      o.slot = h;
      if (!q_valid[h]) begin
        o.status = ST_EMPTY;
      end else if (it.now_time < q_due[h]) begin
        o.status  = ST_NOT_DUE;
        o.retries = q_retries[h];
      end else begin
        o.attempt = 1'b1;
        o.addr    = q_addr[h];
        o.len     = q_len[h];
        if (it.link_ok) begin
          o.status   = ST_SENT;
          o.retries  = q_retries[h];
          q_valid[h] = 1'b0;
          q_head     = h + 3'd1;
        end else if (q_retries[h] == '0) begin
          o.status   = ST_DROPPED;
          q_valid[h] = 1'b0;
          q_head     = h + 3'd1;
        end else begin
          q_retries[h] = q_retries[h] - 8'd1;
          k = (q_kind[h] > OtherKind) ? OtherKind : int'(q_kind[h]);
          q_due[h] = it.now_time + TimeW'(RetryGapMs) + TimeW'(PaceMs[k] >> 1);
          o.status  = ST_RETRY;
          o.retries = q_retries[h];
        end
      end
    end
    return o;
  endfunction

  function automatic rbtq_item_t make_frame(input logic [AddrW-1:0] addr,
                                            input logic [KindW-1:0] kind,
                                            input logic [RetryW-1:0] retry,
                                            input logic [LenW-1:0] len,
                                            input logic [TimeW-1:0] now);
    rbtq_item_t it;
    it = '0;
    it.op          = OP_ENQUEUE;
    it.dest_addr   = addr;
    it.msg_kind    = kind;
    it.retry_limit = retry;
    it.frame_len   = len;
    it.now_time    = now;
    return it;
  endfunction

  function automatic rbtq_item_t make_tick(input logic [TimeW-1:0] now, input logic link);
    rbtq_item_t it;
    it = '0;
    it.op       = OP_TICK;
    it.now_time = now;
    it.link_ok  = link;
    return it;
  endfunction

  task automatic send_item(input rbtq_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= it.op;
    dest_addr_i   <= it.dest_addr;
    msg_kind_i    <= it.msg_kind;
    retry_limit_i <= it.retry_limit;
    frame_len_i   <= it.frame_len;
    now_time_i    <= it.now_time;
    link_ok_i     <= it.link_ok;
    do @(posedge clk_i); while (in_stall_o);
    expected_outcomes.push_back(next_outcome(it));
  endtask

  task automatic release_bus();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Empty tick, length rejects, and a retry whose due time wraps past 2^48.
  task automatic test_reject_and_wrap();
    send_item(make_tick('0, 1'b1));
    send_item(make_frame(AddrMax, 4'd15, 8'd255, 9'd257, TimeMax));
    send_item(make_frame(AddrMax, 4'd15, 8'd255, 9'd511, TimeMax));
    send_item(make_frame(AddrMax, 4'd15, 8'd255, 9'd256, TimeMax));
    send_item(make_tick(TimeMax, 1'b0));
    send_item(make_tick(TimeW'(58), 1'b1));
    send_item(make_tick(TimeW'(59), 1'b1));
    send_item(make_tick(TimeW'(59), 1'b0));
    release_bus();
  endtask

  // Fill every slot, hit full (and too long while full), then drop, retry, not due, drop and send.
  task automatic test_fill_and_drop();
    for (int i = 0; i < Depth; i++) begin
      send_item(make_frame(rand48(), KindW'(2 * i), RetryW'(i), LenW'(32 * i), TimeW'(100)));
    end
    send_item(make_frame(rand48(), 4'd3, 8'd1, 9'd10, TimeW'(100)));
    send_item(make_frame(rand48(), 4'd3, 8'd1, 9'd300, TimeW'(100)));
    send_item(make_tick(TimeW'(100), 1'b0));
    send_item(make_tick(TimeW'(100), 1'b0));
    send_item(make_tick(TimeW'(149), 1'b1));
    send_item(make_tick(TimeW'(150), 1'b0));
    send_item(make_tick(TimeW'(200), 1'b1));
    release_bus();
  endtask

  // Mixed traffic on an advancing clock; a few ticks carry an arbitrary time as noise.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned gap,
                                     input int unsigned stall);
    rbtq_item_t it;
    gap_pct   = gap;
    stall_pct = stall;
    repeat (n_items) begin
      clock_ms = clock_ms + TimeW'(($urandom_range(99) < 70) ? $urandom_range(20)
                                                             : $urandom_range(300));
      it.dest_addr   = rand48();
      it.msg_kind    = KindW'($urandom_range(15));
      it.retry_limit = RetryW'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                        : $urandom_range(3));
      it.frame_len   = LenW'(($urandom_range(9) == 0) ? $urandom_range(511, 257)
                                                      : $urandom_range(256));
      it.now_time    = clock_ms;
      it.link_ok     = 1'($urandom_range(1));
      if ($urandom_range(99) < 50) begin
        it.op = OP_ENQUEUE;
      end else begin
        it.op = OP_TICK;
        if ($urandom_range(19) == 0) begin
          // a link-ok tick at any time pops, finds the queue empty or is not due; never pushes a due date out
          it.now_time = rand48();
          it.link_ok  = 1'b1;
        end
      end
      send_item(it);
    end
    release_bus();
  endtask

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    tx_outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with none expected, status %0h slot %0h", $time, status_o,
                 slot_o);
        mismatches++;
      end else begin
        want = expected_outcomes.pop_front();
        check_field("status", 48'(want.status), 48'(status_o));
        check_field("send_attempt", 48'(want.attempt), 48'(send_attempt_o));
        check_field("slot", 48'(want.slot), 48'(slot_o));
        check_field("send_addr", want.addr, send_addr_o);
        check_field("send_len", 48'(want.len), 48'(send_len_o));
        check_field("retries_remaining", 48'(want.retries), 48'(retries_remaining_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < Depth; i++) q_valid[i] = 1'b0;
    q_head   = '0;
    q_tail   = '0;
    clock_ms = {1'b0, 47'(rand48())};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reject_and_wrap();
    test_fill_and_drop();
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 88, 0);
    test_random_traffic(240, 0, 88);
    test_random_traffic(240, 34, 34);
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rbtq_pkg.sv
hdl/rbtq_in_reg.sv
hdl/rbtq_slots.sv
hdl/rbtq_out_reg.sv
hdl/retry_backoff_tx_queue_core.sv
tb/retry_backoff_tx_queue_core_tb.sv
